### rtl/core/usmbf_pkg.sv
`default_nettype none

package usmbf_pkg;

	// Frame store geometry and window size
	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 256;
	localparam int KSIZE       = 23;
	localparam int KLOW        = (KSIZE - 1) / 2;
	localparam int KK          = KSIZE * KSIZE;

	localparam int PIX_W       = 8;
	localparam int CFG_W       = 9;
	localparam int CFG_IDX_W   = 1;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int POS_W       = $clog2(STORE_DEPTH);
	localparam int TOTAL_W     = 2 * CFG_W;
	localparam int WIDE_W      = ((TOTAL_W > POS_W) ? TOTAL_W : POS_W) + 1;

	localparam int SUM_W       = $clog2(KK * 255 + 1);
	localparam int K_W         = (KSIZE > 1) ? $clog2(KSIZE) : 1;
	localparam int SC_W        = CFG_W + 2;

	// Restoring divider: raster position over frame width
	localparam int DVD_W       = POS_W;
	localparam int DVS_W       = CFG_W;
	localparam int DCNT_W      = $clog2(DVD_W);

	// Window mean by reciprocal multiply, exact for every SUM_W-bit sum
	localparam int               MEAN_SHIFT = SUM_W + $clog2(KK);
	localparam longint unsigned  MEAN_MUL   =
		((64'd1 << MEAN_SHIFT) + 64'(KK) - 64'd1) / 64'(KK);
	localparam int               MEAN_MUL_W = $clog2(MEAN_MUL + 64'd1);
	localparam int               PROD_W     = SUM_W + MEAN_MUL_W;

	localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(256);

	// Command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	typedef struct packed {
		logic             cmd;
		logic [PIX_W-1:0] pixel_in;
	} item_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             last;
	} result_t;

	// Zero counts as one, anything above the maximum saturates
	function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
	                                               input int unsigned maxv);
		logic [CFG_W-1:0] r;
		if (v == '0) begin
			r = CFG_W'(1);
		end else if (32'(v) > maxv) begin
			r = CFG_W'(maxv);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/core/usmbf_ram.sv
`default_nettype none

module usmbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/unsharp_mask_box_filter_unit.sv
`default_nettype none

// Channel   Dir  Payload                    Beat
// item      in   cmd, pixel_in (item_t)     item_valid & item_ready
// result    out  pixel_out, last (result_t) result_valid & result_ready
// cfg       in   cfg_index, cfg_data        cfg_valid & cfg_ready (always ready)
//
// A load beat writes its pixel straight into the frame store.
// Items are taken only in idle, so a new read waits for the last one: the
// restoring divider splits the position into row and column, the window is summed
// one stored pixel per cycle, then one reciprocal multiply takes the mean.
// Reset clears positions, registers and the result slot, not the frame store.
// A held result never blocks loads; a read waits at its end for a free result slot.

module unsharp_mask_box_filter_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              item_valid,
	output logic                                   item_ready,
	input  wire usmbf_pkg::item_t                  item,
	output logic                                   result_valid,
	input  wire logic                              result_ready,
	output usmbf_pkg::result_t                     result,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [usmbf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [usmbf_pkg::CFG_W-1:0]       cfg_data
);

	import usmbf_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_DIVP  = 6'b000010,
		ST_WIN   = 6'b000100,
		ST_DRAIN = 6'b001000,
		ST_MEAN  = 6'b010000,
		ST_PUSH  = 6'b100000
	} state_t;

	state_t state_q;

	// Configuration
	logic [CFG_W-1:0] width_q, height_q;
	logic [CFG_W-1:0] w_eff, h_eff;
	logic [WIDE_W-1:0] total;

	// Positions
	logic [POS_W-1:0]  ld_pos_q, rd_pos_q, cur_pos_q;
	logic [POS_W-1:0]  ld_eff, rd_eff;
	logic [WIDE_W-1:0] ld_inc, rd_inc;
	logic              last_q;

	// Divider
	logic [DVS_W-1:0]  div_rem_q, div_dvs_q;
	logic [DVD_W-1:0]  div_quo_q;
	logic [DCNT_W-1:0] div_cnt_q;
	logic [DVS_W:0]    rem_sh, rem_diff;
	logic              rem_ge;

	// Window walk
	logic [K_W-1:0]         kx_q, ky_q;
	logic signed [SC_W-1:0] xc, yc;
	logic [CFG_W-1:0]       col, row;
	logic [WIDE_W-1:0]      win_addr;
	logic                   win_v_s1, ctr_v_s1;
	logic [SUM_W-1:0]       sum_q, sum_nx;
	logic [PIX_W-1:0]       g_q;

	// Frame store
	logic             st_we, st_re;
	logic [POS_W-1:0] st_waddr, st_raddr;
	logic [PIX_W-1:0] st_rdata;

	// Result
	logic [PROD_W-1:0]  mean_prod;
	logic [PIX_W-1:0]   blur_q, sharp;
	logic [PIX_W+1:0]   two_g, sdiff;
	logic               out_valid_q;
	result_t            out_q;
	logic               push_ok;

	logic item_acc, is_load, is_read;

	assign cfg_ready    = 1'b1;
	assign item_ready   = (state_q == ST_IDLE);
	assign item_acc     = item_valid && item_ready;
	assign is_load      = item_acc && (item.cmd == CMD_LOAD);
	assign is_read      = item_acc && (item.cmd == CMD_READ);
	assign result_valid = out_valid_q;
	assign result       = out_q;
	assign push_ok      = !out_valid_q || result_ready;

	// Effective frame size and pixel count
	always_comb begin
		w_eff = clamp_dim(width_q, MAX_WIDTH);
		h_eff = clamp_dim(height_q, MAX_HEIGHT);
		total = WIDE_W'(w_eff) * WIDE_W'(h_eff);
	end

	// A position beyond a shrunken frame restarts at zero
	always_comb begin
		ld_eff = (WIDE_W'(ld_pos_q) >= total) ? '0 : ld_pos_q;
		rd_eff = (WIDE_W'(rd_pos_q) >= total) ? '0 : rd_pos_q;
		ld_inc = WIDE_W'(ld_eff) + WIDE_W'(1);
		rd_inc = WIDE_W'(rd_eff) + WIDE_W'(1);
	end

	// One restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		rem_sh   = {div_rem_q, div_quo_q[DVD_W-1]};
		rem_diff = rem_sh - {1'b0, div_dvs_q};
		rem_ge   = (rem_sh >= {1'b0, div_dvs_q});
	end

	// Window coordinates with replicated borders; the divider holds
	// row (quotient) and column (remainder) of the centre while walking
	always_comb begin
		yc = $signed({2'b00, div_quo_q[CFG_W-1:0]}) + $signed(SC_W'(ky_q))
		     - $signed(SC_W'(KLOW));
		xc = $signed({2'b00, div_rem_q[CFG_W-1:0]}) + $signed(SC_W'(kx_q))
		     - $signed(SC_W'(KLOW));
		if (yc < 0) begin
			row = '0;
		end else if (yc >= $signed({2'b00, h_eff})) begin
			row = h_eff - CFG_W'(1);
		end else begin
			row = yc[CFG_W-1:0];
		end
		if (xc < 0) begin
			col = '0;
		end else if (xc >= $signed({2'b00, w_eff})) begin
			col = w_eff - CFG_W'(1);
		end else begin
			col = xc[CFG_W-1:0];
		end
		win_addr = WIDE_W'(row) * WIDE_W'(w_eff) + WIDE_W'(col);
	end

	// Frame store ports: loads write in idle, reads fetch the centre, then walk the window
	always_comb begin
		st_we    = is_load;
		st_waddr = ld_eff;
		st_re    = (state_q == ST_DIVP) || (state_q == ST_WIN);
		st_raddr = (state_q == ST_WIN) ? win_addr[POS_W-1:0] : cur_pos_q;
		sum_nx   = win_v_s1 ? (sum_q + SUM_W'(st_rdata)) : sum_q;
	end

	usmbf_ram #(
		.WIDTH(PIX_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(item.pixel_in),
		.re   (st_re),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	// Window mean: sum times the rounded-up reciprocal, high bits kept
	assign mean_prod = PROD_W'(sum_q) * PROD_W'(MEAN_MUL);

	// Sharpen and clamp: 2*g - blur into 0..255
	always_comb begin
		two_g = {1'b0, g_q, 1'b0};
		sdiff = two_g - (PIX_W+2)'(blur_q);
		if ((PIX_W+2)'(blur_q) > two_g) begin
			sharp = '0;
		end else if (sdiff > (PIX_W+2)'(255)) begin
			sharp = '1;
		end else begin
			sharp = sdiff[PIX_W-1:0];
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data;
				REG_FRAME_HEIGHT: height_q <= cfg_data;
				default:          width_q  <= width_q;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ld_pos_q    <= '0;
			rd_pos_q    <= '0;
			div_cnt_q   <= '0;
			kx_q        <= '0;
			ky_q        <= '0;
			win_v_s1    <= 1'b0;
			ctr_v_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			win_v_s1 <= (state_q == ST_WIN);
			ctr_v_s1 <= (state_q == ST_DIVP) && (div_cnt_q == '0);

			// Drop the result beat once taken
			if (out_valid_q && result_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (is_load) begin
						ld_pos_q <= (ld_inc >= total) ? '0 : ld_inc[POS_W-1:0];
					end
					if (is_read) begin
						rd_pos_q  <= (rd_inc >= total) ? '0 : rd_inc[POS_W-1:0];
						div_cnt_q <= DCNT_W'(DVD_W - 1);
						state_q   <= ST_DIVP;
					end
				end
				ST_DIVP: begin
					div_cnt_q <= div_cnt_q - DCNT_W'(1);
					if (div_cnt_q == '0) begin
						kx_q    <= '0;
						ky_q    <= '0;
						state_q <= ST_WIN;
					end
				end
				ST_WIN: begin
					if (kx_q == K_W'(KSIZE - 1)) begin
						kx_q <= '0;
						if (ky_q == K_W'(KSIZE - 1)) begin
							state_q <= ST_DRAIN;
						end else begin
							ky_q <= ky_q + K_W'(1);
						end
					end else begin
						kx_q <= kx_q + K_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_MEAN;
				end
				ST_MEAN: begin
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					// Hold until the result slot is free
					if (push_ok) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (is_read) begin
			cur_pos_q <= rd_eff;
			last_q    <= (WIDE_W'(rd_eff) == total - WIDE_W'(1));
			div_quo_q <= DVD_W'(rd_eff);
			div_dvs_q <= DVS_W'(w_eff);
			div_rem_q <= '0;
		end else if (state_q == ST_DIVP) begin
			div_rem_q <= rem_ge ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
			div_quo_q <= {div_quo_q[DVD_W-2:0], rem_ge};
		end

		// Capture the centre pixel, accumulate the window
		if (ctr_v_s1) begin
			g_q <= st_rdata;
		end
		if ((state_q == ST_DIVP) && (div_cnt_q == '0)) begin
			sum_q <= '0;
		end else begin
			sum_q <= sum_nx;
		end

		// Full window sum is settled in sum_q here
		if (state_q == ST_MEAN) begin
			blur_q <= mean_prod[MEAN_SHIFT +: PIX_W];
		end

		if ((state_q == ST_PUSH) && push_ok) begin
			out_q.pixel_out <= sharp;
			out_q.last      <= last_q;
		end
	end

endmodule

`default_nettype wire
